// ===== rtl/ordered_bypass_request_queue_assert.svh =====
// Assertion macros for the ordered bypass request queue.
// Included by modules that check their own control logic; no other dependencies.
`ifndef ORDERED_BYPASS_REQUEST_QUEUE_ASSERT_SVH
`define ORDERED_BYPASS_REQUEST_QUEUE_ASSERT_SVH

// same-cycle implication
`define OBRQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("obrq check failed");

// next-cycle implication
`define OBRQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("obrq check failed");

`endif

// ===== rtl/obrq_pkg.sv =====
// Shared types and constants for the ordered bypass request queue.
// No dependencies; imported by the cell, the top level and the bench.
package obrq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_BITS    = 16;
   localparam int TIME_BITS   = 32;
   localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] MODE_ENQUEUE    = 3'd0;
   localparam logic [2:0] MODE_TAKE_OLD   = 3'd1;
   localparam logic [2:0] MODE_TAKE_SEND  = 3'd2;
   localparam logic [2:0] MODE_SET_WAIT   = 3'd3;
   localparam logic [2:0] MODE_CLEAR_WAIT = 3'd4;
   localparam logic [2:0] MODE_FLUSH      = 3'd5;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_NONE = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [2:0]           mode;
      logic [TAG_BITS-1:0]  request_tag;
      logic                 request_serialized;
      logic [TIME_BITS-1:0] arrival_time;
   } req_word_type;

   typedef struct packed {
      logic [1:0]           status;
      logic                 taken_valid;
      logic [TAG_BITS-1:0]  taken_tag;
      logic                 taken_serialized;
      logic                 queue_empty;
      logic                 sendable_available;
      logic                 head_time_valid;
      logic [TIME_BITS-1:0] head_time;
      logic [CNT_BITS-1:0]  entry_count;
   } rsp_word_type;

   typedef struct packed {
      logic [TAG_BITS-1:0]  tag;
      logic                 serialized;
      logic [TIME_BITS-1:0] arrival;
   } entry_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic clear;
      logic wait_mark;
   } cell_ctrl_type;

endpackage

// ===== rtl/ordered_bypass_request_queue.sv =====
// Ordered bypass request queue: a collapsing row of slots with oldest and sendable take.
// Each request word is registered, executed against the slot row in S_EXEC, then reported
// from S_REPORT; no new word is accepted until the state is back in S_IDLE.
// The response register lets a new request be taken while a response still waits.
// Reset empties the queue and clears the wait mark. Depends on obrq_pkg, obrq_cell and the assertion header.
`include "ordered_bypass_request_queue_assert.svh"

module ordered_bypass_request_queue
   import obrq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_REPORT = 2'd2;

   logic [1:0]          state_ff;
   logic [1:0]          state_in;
   req_word_type        cmd_ff;
   logic                wait_ff;
   logic                wait_in;
   logic [CNT_BITS-1:0] occ_ff;
   logic [CNT_BITS-1:0] occ_in;
   rsp_word_type        res_ff;
   rsp_word_type        res_in;
   rsp_word_type        rsp_ff;
   rsp_word_type        rsp_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   entry_type            cell_entry [QUEUE_DEPTH];
   entry_type            right_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] right_valid;
   logic [QUEUE_DEPTH-1:0] cell_valid;
   logic [QUEUE_DEPTH-1:0] cell_send;
   cell_ctrl_type        cell_ctrl [QUEUE_DEPTH];

   logic                   req_accept;
   logic                   exec;
   logic                   is_take;
   logic                   is_enqueue;
   logic                   full;
   logic                   found;
   logic [QUEUE_DEPTH-1:0] pick_vec;
   logic [QUEUE_DEPTH-1:0] first_vec;
   logic [QUEUE_DEPTH-1:0] shift_vec;
   logic [QUEUE_DEPTH-1:0] load_vec;
   entry_type              taken_entry;
   entry_type              new_entry;
   logic                   report_load;

   assign req_accept  = req_valid && !req_stall;
   assign req_stall   = (state_ff != S_IDLE);
   assign exec        = (state_ff == S_EXEC);
   assign is_take     = (cmd_ff.mode == MODE_TAKE_OLD) || (cmd_ff.mode == MODE_TAKE_SEND);
   assign is_enqueue  = (cmd_ff.mode == MODE_ENQUEUE);
   assign full        = (occ_ff == CNT_BITS'(QUEUE_DEPTH));
   assign report_load = (state_ff == S_REPORT) && (!rsp_valid_ff || !rsp_stall);

   assign new_entry.tag        = cmd_ff.request_tag;
   assign new_entry.serialized = cmd_ff.request_serialized;
   assign new_entry.arrival    = cmd_ff.arrival_time;

   // pick the first candidate slot as a one-hot word
   assign pick_vec  = (cmd_ff.mode == MODE_TAKE_OLD) ? cell_valid : cell_send;
   assign found     = |pick_vec;
   assign first_vec = pick_vec & (~pick_vec + 1'b1);
   assign shift_vec = found ? ~(first_vec - 1'b1) : '0;
   assign load_vec  = (exec && is_enqueue && !full)
                    ? (QUEUE_DEPTH'(1) << occ_ff[IDX_BITS-1:0]) : '0;

   always_comb begin
      taken_entry = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         taken_entry = taken_entry | (cell_entry[i] & {$bits(entry_type){first_vec[i]}});
      end
   end

   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         if (g == QUEUE_DEPTH - 1) begin : g_last
            assign right_entry[g] = '0;
            assign right_valid[g] = 1'b0;
         end else begin : g_mid
            assign right_entry[g] = cell_entry[g+1];
            assign right_valid[g] = cell_valid[g+1];
         end

         assign cell_ctrl[g].load      = load_vec[g];
         assign cell_ctrl[g].shift     = exec && is_take && shift_vec[g];
         assign cell_ctrl[g].clear     = exec && (cmd_ff.mode == MODE_FLUSH);
         assign cell_ctrl[g].wait_mark = wait_ff;

         obrq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (cell_ctrl[g]),
            .new_entry   (new_entry),
            .right_entry (right_entry[g]),
            .right_valid (right_valid[g]),
            .entry       (cell_entry[g]),
            .valid       (cell_valid[g]),
            .sendable    (cell_send[g])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      occ_in       = occ_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_in          = '0;
            res_in.status   = STATUS_DONE;
            unique case (cmd_ff.mode)
               MODE_ENQUEUE: begin
                  if (full) begin
                     res_in.status = STATUS_FULL;
                  end else begin
                     occ_in = occ_ff + 1'b1;
                  end
               end
               MODE_TAKE_OLD, MODE_TAKE_SEND: begin
                  if (found) begin
                     occ_in                  = occ_ff - 1'b1;
                     res_in.taken_valid      = 1'b1;
                     res_in.taken_tag        = taken_entry.tag;
                     res_in.taken_serialized = taken_entry.serialized;
                  end else begin
                     res_in.status = STATUS_NONE;
                  end
               end
               MODE_SET_WAIT: begin
                  wait_in = 1'b1;
               end
               MODE_CLEAR_WAIT: begin
                  wait_in = 1'b0;
               end
               MODE_FLUSH: begin
                  occ_in = '0;
               end
               default: begin
               end
            endcase
            state_in = S_REPORT;
         end
         S_REPORT: begin
            if (report_load) begin
               rsp_in                    = res_ff;
               rsp_in.queue_empty        = (occ_ff == '0);
               rsp_in.sendable_available = |cell_send;
               rsp_in.head_time_valid    = cell_valid[0];
               rsp_in.head_time          = cell_valid[0] ? cell_entry[0].arrival : '0;
               rsp_in.entry_count        = occ_ff;
               rsp_valid_in              = 1'b1;
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wait_ff      <= 1'b0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff <= req_word;
      end
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `OBRQ_ASSERT_IMP(a_count_matches, clock, reset, 1'b1, $countones(cell_valid) == occ_ff)
   `OBRQ_ASSERT_IMP(a_valid_packed, clock, reset, 1'b1, ((cell_valid >> 1) & ~cell_valid) == '0)
   `OBRQ_ASSERT_NEXT(a_accept_exec, clock, reset, req_accept, state_ff == S_EXEC)
   `OBRQ_ASSERT_NEXT(a_take_shrinks, clock, reset, exec && is_take && found, occ_ff == $past(occ_ff) - 1'b1)
   `OBRQ_ASSERT_IMP(a_head_vs_empty, clock, reset, rsp_valid_ff, rsp_ff.head_time_valid != rsp_ff.queue_empty)

endmodule

// ===== rtl/obrq_cell.sv =====
// One queue slot: holds an entry and its valid bit, takes its right neighbor on a shift.
// Depends on obrq_pkg.
module obrq_cell
   import obrq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  entry_type     new_entry,
   input  entry_type     right_entry,
   input  logic          right_valid,
   output entry_type     entry,
   output logic          valid,
   output logic          sendable
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      valid_ff;
   logic      valid_in;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      priority if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         valid_in = right_valid;
         entry_in = right_entry;
      end else if (ctrl.load) begin
         valid_in = 1'b1;
         entry_in = new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry    = entry_ff;
   assign valid    = valid_ff;
   assign sendable = valid_ff && (!ctrl.wait_mark || !entry_ff.serialized);

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the ordered bypass request queue: directed and random request words,
// with a shadow copy of the queue that works out the response for each accepted word.
// Depends on obrq_pkg and the ordered_bypass_request_queue top level.
module tb
   import obrq_pkg::*;
();

   localparam int RANDOM_WORDS = 1500;
   localparam int IDLE_LIMIT   = 2000;
   localparam int LONG_HOLD    = 150;
   localparam int SETTLE       = 12;

   typedef struct {
      req_word_type word;
      bit           drain_first;
   } request_item_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   request_item_type request_words[$];
   rsp_word_type     queue_reports[$];

   entry_type shadow_entry [QUEUE_DEPTH];
   int        shadow_count = 0;
   bit        shadow_waiting = 1'b0;

   int errors = 0;
   int send_gap = 0;
   int hold_gap = 0;
   int long_hold = 0;
   int reports_seen = 0;
   int idle_cycles = 0;

   ordered_bypass_request_queue u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #1 clock = ~clock;

   function automatic rsp_word_type shadow_execute(req_word_type w);
      rsp_word_type r;
      int pos;
      int i;
      r = '0;
      pos = -1;
      case (w.mode)
         MODE_ENQUEUE: begin
            if (shadow_count >= QUEUE_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               shadow_entry[shadow_count].tag = w.request_tag;
               shadow_entry[shadow_count].serialized = w.request_serialized;
               shadow_entry[shadow_count].arrival = w.arrival_time;
               shadow_count++;
            end
         end
         MODE_TAKE_OLD, MODE_TAKE_SEND: begin
            for (i = 0; i < shadow_count; i++) begin
               if (pos < 0 && (w.mode == MODE_TAKE_OLD || !shadow_waiting ||
                               !shadow_entry[i].serialized))
                  pos = i;
            end
            if (pos < 0) begin
               r.status = STATUS_NONE;
            end else begin
               r.taken_valid = 1'b1;
               r.taken_tag = shadow_entry[pos].tag;
               r.taken_serialized = shadow_entry[pos].serialized;
               for (i = pos; i < shadow_count - 1; i++)
                  shadow_entry[i] = shadow_entry[i + 1];
               shadow_count--;
            end
         end
         MODE_SET_WAIT: shadow_waiting = 1'b1;
         MODE_CLEAR_WAIT: shadow_waiting = 1'b0;
         MODE_FLUSH: shadow_count = 0;
         default: ;
      endcase
      for (i = 0; i < shadow_count; i++) begin
         if (!shadow_waiting || !shadow_entry[i].serialized)
            r.sendable_available = 1'b1;
      end
      r.queue_empty = (shadow_count == 0);
      r.head_time_valid = (shadow_count != 0);
      r.head_time = (shadow_count != 0) ? shadow_entry[0].arrival : '0;
      r.entry_count = CNT_BITS'(shadow_count);
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_word_type make_word(logic [2:0] mode, logic [TAG_BITS-1:0] tag,
                                              logic ser, logic [TIME_BITS-1:0] stamp);
      req_word_type w;
      w.mode = mode;
      w.request_tag = tag;
      w.request_serialized = ser;
      w.arrival_time = stamp;
      return w;
   endfunction

   function automatic logic [2:0] pick_mode(int bias);
      int r;
      int enq;
      int old;
      int snd;
      int st;
      int clr;
      int fl;
      r = $urandom_range(0, 99);
      case (bias)
         0: begin enq = 65; old = 73; snd = 85; st = 90; clr = 95; fl = 96; end
         1: begin enq = 25; old = 50; snd = 80; st = 88; clr = 96; fl = 98; end
         default: begin enq = 45; old = 62; snd = 82; st = 89; clr = 96; fl = 98; end
      endcase
      if (r < enq) return MODE_ENQUEUE;
      if (r < old) return MODE_TAKE_OLD;
      if (r < snd) return MODE_TAKE_SEND;
      if (r < st) return MODE_SET_WAIT;
      if (r < clr) return MODE_CLEAR_WAIT;
      if (r < fl) return MODE_FLUSH;
      return 3'($urandom_range(6, 7));
   endfunction

   task automatic add_word(req_word_type w, bit drain);
      request_item_type item;
      item.word = w;
      item.drain_first = drain;
      request_words.insert(request_words.size(), item);
   endtask

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic check_report(rsp_word_type want, rsp_word_type got);
      compare_field("status", want.status, got.status);
      compare_field("taken_valid", want.taken_valid, got.taken_valid);
      compare_field("taken_tag", want.taken_tag, got.taken_tag);
      compare_field("taken_serialized", want.taken_serialized, got.taken_serialized);
      compare_field("queue_empty", want.queue_empty, got.queue_empty);
      compare_field("sendable_available", want.sendable_available, got.sendable_available);
      compare_field("head_time_valid", want.head_time_valid, got.head_time_valid);
      compare_field("head_time", want.head_time, got.head_time);
      compare_field("entry_count", want.entry_count, got.entry_count);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_word <= '0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall)
            queue_reports.insert(queue_reports.size(), shadow_execute(req_word));
         if (req_valid && req_stall) begin
            // hold the stalled word
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (request_words.size() > 0 &&
                      (!request_words[0].drain_first || queue_reports.size() == 0)) begin
            req_word <= request_words[0].word;
            req_valid <= 1'b1;
            request_words.delete(0);
            send_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_gap = 0;
         long_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (queue_reports.size() == 0) begin
               $display("%0t: unexpected response word, expected none, actual %h",
                        $time, rsp_word);
               errors++;
            end else begin
               check_report(queue_reports[0], rsp_word);
               queue_reports.delete(0);
            end
            reports_seen++;
            if (reports_seen == 300 || reports_seen == 1000)
               long_hold = LONG_HOLD;
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_stall <= 1'b1;
         end else if (hold_gap > 0) begin
            hold_gap--;
            rsp_stall <= 1'b1;
         end else begin
            hold_gap = pick_gap();
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("tb failed");
            $finish;
         end
      end
   end

   initial begin
      int counted;
      int bias;
      int j;
      logic [2:0] mode;
      bit drain;

      add_word(make_word(MODE_TAKE_OLD, 16'h5a5a, 1'b1, 32'h1234_5678), 1'b0);
      add_word(make_word(MODE_TAKE_SEND, 16'ha5a5, 1'b0, 32'h8765_4321), 1'b0);
      add_word(make_word(3'd6, 16'hffff, 1'b1, 32'hffff_ffff), 1'b0);
      add_word(make_word(3'd7, 16'h0000, 1'b0, 32'h0000_0000), 1'b0);
      add_word(make_word(MODE_CLEAR_WAIT, 16'h0001, 1'b0, 32'h1), 1'b0);
      add_word(make_word(MODE_ENQUEUE, 16'hffff, 1'b1, 32'hffff_ffff), 1'b0);
      add_word(make_word(MODE_ENQUEUE, 16'h0000, 1'b0, 32'h0000_0000), 1'b0);
      for (j = 0; j < QUEUE_DEPTH - 2; j++)
         add_word(make_word(MODE_ENQUEUE, 16'($urandom), 1'b1, $urandom), 1'b0);
      add_word(make_word(MODE_ENQUEUE, 16'h7777, 1'b0, 32'h7777_7777), 1'b0);
      add_word(make_word(MODE_SET_WAIT, 16'h0, 1'b0, 32'h0), 1'b0);
      add_word(make_word(MODE_SET_WAIT, 16'h0, 1'b0, 32'h0), 1'b0);
      add_word(make_word(MODE_TAKE_SEND, 16'h0, 1'b0, 32'h0), 1'b0);
      add_word(make_word(MODE_TAKE_SEND, 16'h0, 1'b0, 32'h0), 1'b0);
      add_word(make_word(MODE_TAKE_OLD, 16'h0, 1'b0, 32'h0), 1'b0);
      add_word(make_word(MODE_FLUSH, 16'h0, 1'b0, 32'h0), 1'b0);
      add_word(make_word(MODE_CLEAR_WAIT, 16'h0, 1'b0, 32'h0), 1'b1);

      counted = 0;
      while (counted < RANDOM_WORDS) begin
         bias = $urandom_range(0, 2);
         for (j = 0; j < 60; j++) begin
            mode = pick_mode(bias);
            drain = ($urandom_range(0, 199) == 0) || (counted == RANDOM_WORDS / 2);
            add_word(make_word(mode, 16'($urandom), 1'($urandom), $urandom), drain);
            if (mode <= MODE_FLUSH)
               counted++;
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (request_words.size() > 0 || req_valid || queue_reports.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (errors == 0 && queue_reports.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
